// File: src/swerc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerc_pkg
// Shared widths, codes and control structs of the event rate checker.
// ----------------------------------------------------------------------------
package swerc_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int OP_W         = 2;
    localparam int TIME_W       = 32;
    localparam int NEED_W       = 8;
    localparam int KEEP_COUNT_W = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // item operation codes; code 3 is a no-op
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_AGE   = 1'b1;

    typedef struct packed {
        logic load;         // capture the accepted item
        logic clear;        // empty the store
        logic add_write;    // append the stamp
        logic trim;         // cut down to keep_count
        logic scan_init;    // arm the ring walk
        logic scan_step;    // advance the ring walk
        logic result_load;  // fill the output register
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

// File: src/swerc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerc_in_if
// Item channel: operation, time, needed count and window.
// ----------------------------------------------------------------------------
interface swerc_in_if;
    logic                          valid;
    logic                          ready;
    logic [swerc_pkg::OP_W-1:0]    op;
    logic [swerc_pkg::TIME_W-1:0]  now;
    logic [swerc_pkg::NEED_W-1:0]  need_count;
    logic [swerc_pkg::TIME_W-1:0]  window;

    modport source (output valid, op, now, need_count, window, input ready);
    modport sink   (input valid, op, now, need_count, window, output ready);
endinterface

// File: src/swerc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerc_out_if
// Result channel: check outcome and stored event count.
// ----------------------------------------------------------------------------
interface swerc_out_if #(
    parameter int CNT_W = 7
);
    logic             valid;
    logic             ready;
    logic             met;
    logic [CNT_W-1:0] held_count;

    modport source (output valid, met, held_count, input ready);
    modport sink   (input valid, met, held_count, output ready);
endinterface

// File: src/swerc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerc_ctrl
// Sequencer: add = append, trim, ring walk; check = ring walk; all end in result.
// ----------------------------------------------------------------------------
module swerc_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [swerc_pkg::OP_W-1:0] i_op,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output swerc_pkg::t_cmd            o_cmd,
    input  swerc_pkg::t_sts            i_sts
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADD  = 6'b000010,
        S_TRIM = 6'b000100,
        S_INIT = 6'b001000,
        S_SCAN = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        swerc_pkg::OP_ADD:   n_state = S_ADD;
                        swerc_pkg::OP_CHECK: n_state = S_INIT;
                        swerc_pkg::OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_DONE;
                        end
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.add_write = 1'b1;
                n_state         = S_TRIM;
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_INIT;
            end
            S_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.result_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// File: src/swerc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerc_dp
// Stamp ring, pointers, thresholds, ring walker and result register.
// ----------------------------------------------------------------------------
module swerc_dp #(
    parameter int DEPTH = swerc_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  swerc_pkg::t_cmd                    i_cmd,
    output swerc_pkg::t_sts                    o_sts,
    input  logic [swerc_pkg::OP_W-1:0]         i_op,
    input  logic [swerc_pkg::TIME_W-1:0]       i_now,
    input  logic [swerc_pkg::NEED_W-1:0]       i_need_count,
    input  logic [swerc_pkg::TIME_W-1:0]       i_window,
    input  logic                               i_cfg_we,
    input  logic [swerc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [swerc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                               o_met,
    output logic [CNT_W-1:0]                   o_held_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = CNT_W + 1;
    localparam int LIM_W = (CNT_W > swerc_pkg::KEEP_COUNT_W) ? CNT_W : swerc_pkg::KEEP_COUNT_W;
    localparam int CMP_W = (CNT_W > swerc_pkg::NEED_W) ? CNT_W : swerc_pkg::NEED_W;
    localparam int TW    = swerc_pkg::TIME_W;

    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    // sum below twice the depth folds back with one compare and subtract
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return t[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_P) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TW-1:0] sat_sub(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

    logic [TW-1:0]                       r_mem [DEPTH];
    logic [PTR_W-1:0]                    r_oldest;
    logic [CNT_W-1:0]                    r_occ;
    logic [swerc_pkg::KEEP_COUNT_W-1:0]  r_keep_count;
    logic [TW-1:0]                       r_keep_age;
    logic [TW-1:0]                       r_now;
    logic [swerc_pkg::NEED_W-1:0]        r_need;
    logic [TW-1:0]                       r_thr;
    logic                                r_prune;
    logic                                r_is_chk;
    logic [PTR_W-1:0]                    r_rd_ptr;
    logic [CNT_W-1:0]                    r_left;
    logic                                r_rvld;
    logic [TW-1:0]                       r_rdata;
    logic [CNT_W-1:0]                    r_count;
    logic                                r_met;
    logic [CNT_W-1:0]                    r_held;

    logic                                add_full;
    logic [PTR_W-1:0]                    add_waddr;
    logic [LIM_W-1:0]                    lim;
    logic [LIM_W-1:0]                    occ_l;
    logic                                over;
    logic [PTR_W-1:0]                    trim_oldest;
    logic                                stale;
    logic                                stop;
    logic                                issue;

    assign add_full  = (r_occ == DEPTH_C);
    assign add_waddr = add_full ? r_oldest
                                : ring_wrap(SUM_W'(r_oldest) + SUM_W'(r_occ));

    assign occ_l       = LIM_W'(r_occ);
    assign lim         = (LIM_W'(r_keep_count) > DEPTH_L) ? DEPTH_L : LIM_W'(r_keep_count);
    assign over        = (occ_l > lim);
    assign trim_oldest = ring_wrap(SUM_W'(r_oldest) + SUM_W'(occ_l - lim));

    // walker: one stamp read per cycle, compared in the cycle after the read
    assign stale = (r_rdata < r_thr);
    assign stop  = r_prune && r_rvld && !stale;
    assign issue = i_cmd.scan_step && (r_left != '0) && !stop;
    assign o_sts.scan_done = stop || ((r_left == '0) && !r_rvld);

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            r_mem[add_waddr] <= r_now;
        end
        if (issue) begin
            r_rdata <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest     <= '0;
            r_occ        <= '0;
            r_keep_count <= '0;
            r_keep_age   <= '0;
            r_rvld       <= 1'b0;
            r_left       <= '0;
            r_prune      <= 1'b0;
            r_is_chk     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swerc_pkg::CFG_KEEP_COUNT:
                        r_keep_count <= i_cfg_data[swerc_pkg::KEEP_COUNT_W-1:0];
                    swerc_pkg::CFG_KEEP_AGE:
                        r_keep_age <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_prune  <= (i_op == swerc_pkg::OP_ADD);
                r_is_chk <= (i_op == swerc_pkg::OP_CHECK);
            end

            if (i_cmd.clear) begin
                r_oldest <= '0;
                r_occ    <= '0;
            end else if (i_cmd.add_write) begin
                // full store: the oldest slot is reused for the new stamp
                if (add_full) begin
                    r_oldest <= ptr_inc(r_oldest);
                end else begin
                    r_occ <= r_occ + 1'b1;
                end
            end else if (i_cmd.trim) begin
                if (over) begin
                    r_oldest <= trim_oldest;
                    r_occ    <= lim[CNT_W-1:0];
                end
            end else if (i_cmd.scan_step && r_prune && r_rvld && stale) begin
                r_oldest <= ptr_inc(r_oldest);
                r_occ    <= r_occ - 1'b1;
            end

            if (i_cmd.scan_init) begin
                r_left <= r_occ;
                r_rvld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rvld <= issue;
                if (issue) begin
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now  <= i_now;
            r_need <= i_need_count;
            r_thr  <= (i_op == swerc_pkg::OP_ADD) ? sat_sub(i_now, r_keep_age)
                                                  : sat_sub(i_now, i_window);
        end
        if (i_cmd.scan_init) begin
            r_rd_ptr <= r_oldest;
            r_count  <= '0;
        end else if (i_cmd.scan_step) begin
            if (issue) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (!r_prune && r_rvld && !stale) begin
                r_count <= r_count + 1'b1;
            end
        end
        if (i_cmd.result_load) begin
            r_met  <= r_is_chk && (CMP_W'(r_count) >= CMP_W'(r_need));
            r_held <= r_occ;
        end
    end

    assign o_met        = r_met;
    assign o_held_count = r_held;

endmodule

// File: src/sliding_window_event_rate_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_event_rate_check
// Event stamp store with count and age trimming and windowed rate check.
// ----------------------------------------------------------------------------
// One item is worked at a time and every item gives one result beat. The stamp
// ring sits in a single-port memory that is walked one stamp per cycle.
// A clear or no-op item goes straight from acceptance to the result load. A
// check arms the ring walk, walks the n stored stamps and loads the result.
// An add appends its stamp, trims to the kept count and walks the m stamps
// left after the count trim, dropping each one that is too old; the walk
// stops at the first stamp young enough, or when none remain. The next item
// can be taken in the cycle after the result load. It is taken as soon as
// the result sits in the output register, even if the sink has not taken it
// yet. A stalled sink holds the following item in its last step. The user
// must write configuration only while the block is idle; the block itself
// does not enforce it. No clearing pass follows reset.
module sliding_window_event_rate_check #(
    parameter int DEPTH = swerc_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    swerc_in_if.sink                           i_in,
    swerc_out_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [swerc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [swerc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    swerc_pkg::t_cmd cmd;
    swerc_pkg::t_sts sts;
    logic            in_ready;
    logic            out_valid;
    logic            met;
    logic [CNT_W-1:0] held_count;

    swerc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    swerc_dp #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_in.op),
        .i_now        (i_in.now),
        .i_need_count (i_in.need_count),
        .i_window     (i_in.window),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_met        (met),
        .o_held_count (held_count)
    );

    assign i_in.ready       = in_ready;
    assign o_out.valid      = out_valid;
    assign o_out.met        = met;
    assign o_out.held_count = held_count;

    // one item in flight: ready drops right after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("item accepted while previous item still in work");

    // store never reports more stamps than it can hold
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (held_count <= CNT_W'(DEPTH)))
        else $error("held_count above depth");

    // a new result appears only after the sequencer was busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result beat without item in work");

    // result beat holds steady while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !o_out.ready) |=>
            (out_valid && $stable(met) && $stable(held_count)))
        else $error("result beat changed while stalled");

endmodule
